// ===== hdl/crs_pkg.sv =====
// Package for the Cauchy Reed-Solomon parity encoder: GF(256) multiply,
// inverse table, cell control struct and controller state type.
// No dependencies.
package crs_pkg;

  localparam logic [8:0] GF_POLY       = 9'h11D;
  localparam logic [8:0] GF_HIGH       = 9'h100;
  localparam logic [7:0] MEMBER_OFFSET = 8'd128;

  typedef logic [7:0] byte_table_t [256];

  typedef struct packed {
    logic acc_en;
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic {
    ST_ACCEPT,
    ST_DRAIN
  } state_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x[7:0];
      end
      x = x << 1;
      if ((x & GF_HIGH) != 9'd0) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  function automatic byte_table_t build_inv_table();
    byte_table_t t;
    for (int a = 0; a < 256; a++) begin
      t[a] = 8'd0;
      for (int b = 1; b < 256; b++) begin
        if (gf_mul(8'(a), 8'(b)) == 8'd1) begin
          t[a] = 8'(b);
        end
      end
    end
    return t;
  endfunction

  localparam byte_table_t INV_TABLE = build_inv_table();

endpackage

// ===== hdl/cauchy_rs_erasure_encoder.sv =====
// Top level of the Cauchy Reed-Solomon parity encoder: chain of row cells,
// drain controller, output register. Depends on crs_pkg and crs_cell.
//
//   channel | signals                                         | direction
//   in      | in_valid in_ready symbol_byte member_index      | to block
//           | last_member                                     |
//   out     | out_valid out_ready parity_byte parity_row      | from block
//           | last_row                                        |
//   cfg     | cfg_valid cfg_ready cfg_data                    | to block
//
// Every cell accumulates each accepted input beat at once.
// After the last member's beat the chain shifts one row per cycle into the
// output register, as long as out_ready does not stall it.
// Input is held off while the chain drains; a stalled out_ready holds the drain.
// Synchronous reset clears the accumulators and sets rows to 2.
module cauchy_rs_erasure_encoder #(
  parameter int MAX_PARITY  = 64,
  parameter int MAX_MEMBERS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol_byte,
  input  logic [6:0] member_index,
  input  logic       last_member,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] parity_byte,
  output logic [5:0] parity_row,
  output logic       last_row,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int ROW_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
  localparam logic [7:0] MAX_PARITY_B  = 8'(MAX_PARITY);
  localparam logic [7:0] MAX_MEMBERS_B = 8'(MAX_MEMBERS);

  crs_pkg::state_t    state, state_next;
  crs_pkg::cell_ctl_t ctl;
  logic [6:0]         rows_cfg;
  logic [6:0]         drain_rows, drain_rows_next;
  logic [ROW_W-1:0]   row_cnt, row_cnt_next;
  logic [7:0]         acc [MAX_PARITY];
  logic               in_fire;
  logic               step;
  logic               final_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= 7'd2;
    end else if (cfg_valid && cfg_data != 7'd0 && {1'b0, cfg_data} <= MAX_PARITY_B) begin
      rows_cfg <= cfg_data;
    end
  end

  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
    logic [7:0] shift_in;
    if (i == MAX_PARITY - 1) begin : g_end
      assign shift_in = 8'd0;
    end else begin : g_mid
      assign shift_in = acc[i+1];
    end
    crs_cell #(.ROW(i)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .symbol_byte  (symbol_byte),
      .member_index (member_index),
      .shift_in     (shift_in),
      .acc          (acc[i])
    );
  end

  always_comb begin
    in_ready        = (state == crs_pkg::ST_ACCEPT);
    in_fire         = in_valid && in_ready;
    step            = (state == crs_pkg::ST_DRAIN) && (!out_valid || out_ready);
    final_row       = (8'(row_cnt) + 8'd1) == {1'b0, drain_rows};
    ctl.acc_en      = in_fire && ({1'b0, member_index} < MAX_MEMBERS_B);
    ctl.shift       = step && !final_row;
    ctl.clear       = step && final_row;
    state_next      = state;
    row_cnt_next    = row_cnt;
    drain_rows_next = drain_rows;
    unique case (state)
      crs_pkg::ST_ACCEPT: begin
        if (in_fire && last_member) begin
          state_next   = crs_pkg::ST_DRAIN;
          row_cnt_next = '0;
          if ({1'b0, rows_cfg} > MAX_PARITY_B) begin
            drain_rows_next = 7'(MAX_PARITY);
          end else begin
            drain_rows_next = rows_cfg;
          end
        end
      end
      crs_pkg::ST_DRAIN: begin
        if (step) begin
          if (final_row) begin
            state_next = crs_pkg::ST_ACCEPT;
          end else begin
            row_cnt_next = row_cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = crs_pkg::ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= crs_pkg::ST_ACCEPT;
      row_cnt    <= '0;
      drain_rows <= 7'd1;
    end else begin
      state      <= state_next;
      row_cnt    <= row_cnt_next;
      drain_rows <= drain_rows_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      parity_byte <= acc[0];
      parity_row  <= 6'(row_cnt);
      last_row    <= final_row;
    end
  end

endmodule

// ===== hdl/crs_cell.sv =====
// One parity row cell: accumulates coefficient times byte, shifts toward
// row zero while draining. Depends on crs_pkg.
module crs_cell #(
  parameter int ROW = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  crs_pkg::cell_ctl_t ctl,
  input  logic [7:0]         symbol_byte,
  input  logic [6:0]         member_index,
  input  logic [7:0]         shift_in,
  output logic [7:0]         acc
);

  logic [7:0] coef_arg;
  logic [7:0] coef;
  logic [7:0] acc_next;

  always_comb begin
    coef_arg = 8'(ROW) ^ (crs_pkg::MEMBER_OFFSET + {1'b0, member_index});
    coef     = crs_pkg::INV_TABLE[coef_arg];
    priority if (ctl.clear) begin
      acc_next = 8'd0;
    end else if (ctl.shift) begin
      acc_next = shift_in;
    end else if (ctl.acc_en) begin
      acc_next = acc ^ crs_pkg::gf_mul(coef, symbol_byte);
    end else begin
      acc_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule
